// ----- rtl/tneg_pkg.sv -----
`default_nettype none
package tneg_pkg;

  localparam int COORD_BITS  = 32;
  localparam int CW          = 32;
  localparam int LIM_W       = 31;
  localparam int NORM_W      = 16;
  localparam int A_W         = 24;
  localparam int SQRT_STEPS  = 32;
  localparam int SQRT_TOP    = 62;
  localparam int Q_W         = 32;
  localparam int DIV_STEPS   = 16;
  localparam int NUM_W       = 47;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;

  localparam logic [LIM_W-1:0]  LIMIT_RESET = LIM_W'(32768);
  localparam logic [NORM_W-1:0] UNIT_Q14    = NORM_W'(16384);

  typedef struct packed {
    logic               reject;
    logic [2:0][CW-1:0] u;
    logic [2:0][CW-1:0] v;
  } work_t;

  function automatic logic [CW-1:0] sext_coord(input logic [CW-1:0] x);
    return CW'($signed(x << (CW - COORD_BITS)) >>> (CW - COORD_BITS));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tneg_front.sv -----
`default_nettype none
module tneg_front import tneg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [LIM_W-1:0]      edge_limit,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [8:0][CW-1:0]    in_coord,
  output logic                  out_valid,
  input  logic                  out_ready,
  output work_t                 out_work
);

  logic                   en;
  logic                   f1_valid, f2_valid, f3_valid;
  logic [8:0][CW-1:0]     f1_p;
  logic [2:0][2:0][30:0]  f2_mag, f2_mag_next;
  logic [2:0]             f2_big, f2_big_next;
  logic                   f2_empty, f2_empty_next;
  logic [2:0][CW-1:0]     f2_u, f2_v, f2_u_next, f2_v_next;
  logic [2:0][2:0][61:0]  f3_sq;
  logic [2:0]             f3_big;
  logic                   f3_empty;
  logic [2:0][CW-1:0]     f3_u, f3_v;
  logic [61:0]            lim2;
  logic [2:0]             over;

  assign en       = !f3_valid || out_ready;
  assign in_ready = en;
  assign out_valid = f3_valid;

  always_ff @(posedge clk) begin
    lim2 <= 62'(edge_limit) * 62'(edge_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  // edge order: a-b, a-c, b-c
  always_comb begin
    logic signed [CW:0] d;
    logic [CW:0]        m;
    int                 pa, pb;
    f2_big_next   = '0;
    f2_empty_next = 1'b0;
    f2_mag_next   = '0;
    for (int e = 0; e < 3; e++) begin
      pa = (e == 2) ? 1 : 0;
      pb = (e == 0) ? 1 : 2;
      for (int k = 0; k < 3; k++) begin
        d = $signed({f1_p[pb*3+k][CW-1], f1_p[pb*3+k]})
          - $signed({f1_p[pa*3+k][CW-1], f1_p[pa*3+k]});
        m = d[CW] ? (~d + 1'b1) : d;
        f2_mag_next[e][k] = m[30:0];
        if (m[CW:31] != '0) f2_big_next[e] = 1'b1;
      end
    end
    for (int t = 0; t < 3; t++) begin
      if (f1_p[t*3] == '0 && f1_p[t*3+1] == '0 && f1_p[t*3+2] == '0) f2_empty_next = 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      f2_u_next[k] = f1_p[3+k] - f1_p[k];
      f2_v_next[k] = f1_p[6+k] - f1_p[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) f1_p[i] <= sext_coord(in_coord[i]);
      f2_mag   <= f2_mag_next;
      f2_big   <= f2_big_next;
      f2_empty <= f2_empty_next;
      f2_u     <= f2_u_next;
      f2_v     <= f2_v_next;
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          f3_sq[e][k] <= 62'(f2_mag[e][k]) * 62'(f2_mag[e][k]);
        end
      end
      f3_big   <= f2_big;
      f3_empty <= f2_empty;
      f3_u     <= f2_u;
      f3_v     <= f2_v;
    end
  end

  always_comb begin
    logic [63:0] sum;
    for (int e = 0; e < 3; e++) begin
      sum = 64'(f3_sq[e][0]) + 64'(f3_sq[e][1]) + 64'(f3_sq[e][2]);
      over[e] = sum > 64'(lim2);
    end
    out_work.reject = f3_empty || (f3_big != '0) || (over != '0);
    out_work.u      = f3_u;
    out_work.v      = f3_v;
  end

endmodule
`default_nettype wire

// ----- rtl/tneg_fifo.sv -----
`default_nettype none
module tneg_fifo import tneg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t din,
  output logic  full,
  input  logic  pop,
  output work_t dout,
  output logic  empty
);

  work_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full  = count == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tneg_back.sv -----
`default_nettype none
module tneg_back import tneg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  work_t                   in_work,
  input  logic                    in_empty,
  output logic                    in_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_accepted,
  output logic [2:0][NORM_W-1:0]  out_norm
);

  logic en;

  logic                     b1_v, b2_v, b3_v, b4_v, b5_v, b6_v, b7_v, b8_v;
  logic                     b1_rej, b2_rej, b3_rej;
  logic signed [5:0][63:0]  b1_p;
  logic signed [2:0][63:0]  b2_c;
  logic [2:0][63:0]         b3_a, b4_a, b5_a, b6_a;
  logic [2:0]               b3_neg, b4_neg, b5_neg, b6_neg, b7_neg, b8_neg;
  logic [63:0]              b4_mx;
  logic                     b4_ok, b5_ok, b6_ok, b7_ok, b8_ok;
  logic [2:0]               b5_grp, grp_next;
  logic [7:0]               b5_byte, byte_next;
  logic [5:0]               b6_pos;
  logic [2:0]               hb_next;
  logic [2:0][A_W-1:0]      b7_a, b8_a, a_next;
  logic [2:0][47:0]         b8_sq;

  logic [63:0]              sq_x   [SQRT_STEPS+1];
  logic [63:0]              sq_r   [SQRT_STEPS+1];
  logic [2:0][A_W-1:0]      sq_a   [SQRT_STEPS+1];
  logic [2:0]               sq_neg [SQRT_STEPS+1];
  logic                     sq_ok  [SQRT_STEPS+1];
  logic                     sq_v   [SQRT_STEPS+1];

  logic [2:0][NUM_W-1:0]    dv_rem [DIV_STEPS+1];
  logic [2:0][DIV_STEPS-1:0] dv_quo [DIV_STEPS+1];
  logic [Q_W-1:0]           dv_q   [DIV_STEPS+1];
  logic [2:0]               dv_neg [DIV_STEPS+1];
  logic                     dv_ok  [DIV_STEPS+1];
  logic                     dv_v   [DIV_STEPS+1];

  assign en     = !out_valid || out_ready;
  assign in_pop = en && !in_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      {b1_v, b2_v, b3_v, b4_v, b5_v, b6_v, b7_v, b8_v} <= '0;
      sq_v[0]   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_v      <= in_pop;
      b2_v      <= b1_v;
      b3_v      <= b2_v;
      b4_v      <= b3_v;
      b5_v      <= b4_v;
      b6_v      <= b5_v;
      b7_v      <= b6_v;
      b8_v      <= b7_v;
      sq_v[0]   <= b8_v;
      out_valid <= dv_v[DIV_STEPS];
    end
  end

  // cross product, magnitude and largest component
  always_ff @(posedge clk) begin
    if (en) begin
      b1_rej  <= in_work.reject;
      b1_p[0] <= $signed(in_work.u[1]) * $signed(in_work.v[2]);
      b1_p[1] <= $signed(in_work.u[2]) * $signed(in_work.v[1]);
      b1_p[2] <= $signed(in_work.u[2]) * $signed(in_work.v[0]);
      b1_p[3] <= $signed(in_work.u[0]) * $signed(in_work.v[2]);
      b1_p[4] <= $signed(in_work.u[0]) * $signed(in_work.v[1]);
      b1_p[5] <= $signed(in_work.u[1]) * $signed(in_work.v[0]);
      b2_rej  <= b1_rej;
      b2_c[0] <= b1_p[0] - b1_p[1];
      b2_c[1] <= b1_p[2] - b1_p[3];
      b2_c[2] <= b1_p[4] - b1_p[5];
      b3_rej  <= b2_rej;
      for (int k = 0; k < 3; k++) begin
        b3_a[k]   <= b2_c[k][63] ? (~b2_c[k] + 1'b1) : b2_c[k];
        b3_neg[k] <= b2_c[k][63];
      end
      b4_a   <= b3_a;
      b4_neg <= b3_neg;
      b4_mx  <= (b3_a[0] >= b3_a[1] && b3_a[0] >= b3_a[2]) ? b3_a[0] :
                (b3_a[1] >= b3_a[2]) ? b3_a[1] : b3_a[2];
      b4_ok  <= !b3_rej && (b3_a != '0);
    end
  end

  // leading one search in two steps, then the shift
  always_comb begin
    grp_next = '0;
    for (int g = 0; g < 8; g++) begin
      if (b4_mx[g*8 +: 8] != '0) grp_next = 3'(g);
    end
    byte_next = b4_mx[grp_next*8 +: 8];
    hb_next = '0;
    for (int b = 0; b < 8; b++) begin
      if (b5_byte[b]) hb_next = 3'(b);
    end
    for (int k = 0; k < 3; k++) begin
      if (b6_pos >= 6'd24) a_next[k] = A_W'(b6_a[k] >> (b6_pos - 6'd23));
      else                 a_next[k] = A_W'(b6_a[k] << (6'd23 - b6_pos));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b5_grp  <= grp_next;
      b5_byte <= byte_next;
      b5_a    <= b4_a;
      b5_neg  <= b4_neg;
      b5_ok   <= b4_ok;
      b6_pos  <= {b5_grp, hb_next};
      b6_a    <= b5_a;
      b6_neg  <= b5_neg;
      b6_ok   <= b5_ok;
      b7_a    <= a_next;
      b7_neg  <= b6_neg;
      b7_ok   <= b6_ok;
      for (int k = 0; k < 3; k++) b8_sq[k] <= 48'(b7_a[k]) * 48'(b7_a[k]);
      b8_a    <= b7_a;
      b8_neg  <= b7_neg;
      b8_ok   <= b7_ok;
      sq_x[0]   <= (64'(b8_sq[0]) + 64'(b8_sq[1]) + 64'(b8_sq[2])) << 12;
      sq_r[0]   <= '0;
      sq_a[0]   <= b8_a;
      sq_neg[0] <= b8_neg;
      sq_ok[0]  <= b8_ok;
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (SQRT_TOP - 2*j);
    logic [63:0] cand;
    assign cand = sq_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else if (en) sq_v[j+1] <= sq_v[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_x[j] >= cand) begin
          sq_x[j+1] <= sq_x[j] - cand;
          sq_r[j+1] <= (sq_r[j] >> 1) + BIT;
        end else begin
          sq_x[j+1] <= sq_x[j];
          sq_r[j+1] <= sq_r[j] >> 1;
        end
        sq_a[j+1]   <= sq_a[j];
        sq_neg[j+1] <= sq_neg[j];
        sq_ok[j+1]  <= sq_ok[j];
      end
    end
  end

  // rounded numerators
  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= sq_v[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= NUM_W'({sq_a[SQRT_STEPS][k], 20'b0})
                      + NUM_W'(sq_r[SQRT_STEPS][Q_W-1:0] >> 1);
      end
      dv_quo[0] <= '0;
      dv_q[0]   <= sq_r[SQRT_STEPS][Q_W-1:0];
      dv_neg[0] <= sq_neg[SQRT_STEPS];
      dv_ok[0]  <= sq_ok[SQRT_STEPS];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - 1 - j;
    logic [NUM_W-1:0] trial;
    assign trial = NUM_W'(dv_q[j]) << K;
    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (en) dv_v[j+1] <= dv_v[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (dv_rem[j][k] >= trial) begin
            dv_rem[j+1][k]    <= dv_rem[j][k] - trial;
            dv_quo[j+1][k]    <= dv_quo[j][k] | (DIV_STEPS'(1) << K);
          end else begin
            dv_rem[j+1][k]    <= dv_rem[j][k];
            dv_quo[j+1][k]    <= dv_quo[j][k];
          end
        end
        dv_q[j+1]   <= dv_q[j];
        dv_neg[j+1] <= dv_neg[j];
        dv_ok[j+1]  <= dv_ok[j];
      end
    end
  end

  // output register: cap, sign, zero on reject
  always_ff @(posedge clk) begin
    logic [NORM_W-1:0] n;
    if (en) begin
      out_accepted <= dv_ok[DIV_STEPS];
      for (int k = 0; k < 3; k++) begin
        n = (dv_quo[DIV_STEPS][k] > UNIT_Q14) ? UNIT_Q14 : dv_quo[DIV_STEPS][k];
        if (!dv_ok[DIV_STEPS])        out_norm[k] <= '0;
        else if (dv_neg[DIV_STEPS][k]) out_norm[k] <= ~n + 1'b1;
        else                          out_norm[k] <= n;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/triangle_normal_edge_gated.sv -----
// triangle normal with empty-point and edge-length gating
//
// s_axis: one triangle per transfer, nine signed q16.16 coordinates.
// m_axis: one result per triangle, in order. tuser is the accept flag, tdata
//   the unit normal in signed q1.14, zero when the triangle is rejected
//   (empty point, edge over the limit, or zero cross product).
// cfg: writes edge_limit (unsigned q15.16, reset 0.5), always ready; write it
//   only while no triangle is in flight.
// throughput: one triangle per cycle while m_axis_tready is high. the path from
//   input to output runs through the 32-stage square root and the 16-stage divider.
// a 4-entry queue splits the edge test front end from the normal pipeline;
//   when the receiver stalls, the normal pipeline holds, the queue fills and
//   then s_axis_tready drops.
// reset: synchronous, clears all valid flags and the queue, and restores the
//   edge limit.
`default_nettype none
module triangle_normal_edge_gated import tneg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [30:0]   cfg_data,      // edge_limit
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [287:0]  s_axis_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [47:0]   m_axis_tdata,  // norm_x, norm_y, norm_z
  output logic [0:0]    m_axis_tuser   // accepted
);

  logic [LIM_W-1:0]         edge_limit;
  logic                     f_valid, f_ready, q_full, q_empty, q_pop;
  work_t                    f_work, q_work;
  logic [2:0][NORM_W-1:0]   norm;
  logic                     acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) edge_limit <= LIMIT_RESET;
    else if (cfg_valid) edge_limit <= cfg_data;
  end

  tneg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .edge_limit (edge_limit),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_coord   (s_axis_tdata),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_work   (f_work)
  );

  assign f_ready = !q_full;

  tneg_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid && !q_full),
    .din   (f_work),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_work),
    .empty (q_empty)
  );

  tneg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_work      (q_work),
    .in_empty     (q_empty),
    .in_pop       (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_accepted (acc),
    .out_norm     (norm)
  );

  assign m_axis_tdata = {norm[2], norm[1], norm[0]};
  assign m_axis_tuser = acc;

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("rejected result with nonzero normal");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      $signed(norm[0]) >= -16384 && $signed(norm[0]) <= 16384 &&
      $signed(norm[1]) >= -16384 && $signed(norm[1]) <= 16384 &&
      $signed(norm[2]) >= -16384 && $signed(norm[2]) <= 16384)
    else $error("normal component out of unit range");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
